/* rtl/s2cd_pkg.sv */
`default_nettype none
package s2cd_pkg;

  localparam int unsigned SecsW   = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned DaysW   = 16;  // whole days since epoch, at most 49710
  localparam int unsigned QuotW   = 17;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned DivW    = 17;
  localparam int unsigned SubW    = SecsW + 1;
  localparam int unsigned YlenW   = 9;
  localparam int unsigned PcW     = 4;

  localparam logic [YearW-1:0]  EpochYear      = 12'd2017;
  // Only century year inside 2017..2153 that is not a leap year
  localparam logic [YearW-1:0]  CenturyNoLeap  = 12'd2100;
  localparam logic [DivW-1:0]   SecsPerDay     = 17'd86400;
  localparam logic [DivW-1:0]   SecsPerHour    = 17'd3600;
  localparam logic [DivW-1:0]   SecsPerMin     = 17'd60;
  localparam logic [DivW-1:0]   DaysPerWeek    = 17'd7;
  localparam logic [YlenW-1:0]  DaysLeapYear   = 9'd366;
  localparam logic [YlenW-1:0]  DaysCommonYear = 9'd365;
  localparam logic [MonthW-1:0] FirstMonth     = 4'd1;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DIV,
    OP_MOVQ,
    OP_SWAP,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_HOUR,
    DV_MIN,
    DV_WEEK
  } dsel_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_DAYS,
    DST_HOUR,
    DST_MIN,
    DST_SEC,
    DST_WDAY
  } dst_e;

  typedef struct packed {
    op_e              op;
    dsel_e            dsel;
    dst_e             dst;
    logic [ShiftW-1:0] k;
    pc_t              tgt;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic k_nz;
    logic ge;
    logic out_free;
  } stat_t;

  localparam pc_t ST_WAIT   = 4'd0;
  localparam pc_t ST_DDAY   = 4'd1;
  localparam pc_t ST_MDAY   = 4'd2;
  localparam pc_t ST_DHOUR  = 4'd3;
  localparam pc_t ST_MHOUR  = 4'd4;
  localparam pc_t ST_DMIN   = 4'd5;
  localparam pc_t ST_MMIN   = 4'd6;
  localparam pc_t ST_SSEC   = 4'd7;
  localparam pc_t ST_DWEEK  = 4'd8;
  localparam pc_t ST_SWDAY  = 4'd9;
  localparam pc_t ST_YEAR   = 4'd10;
  localparam pc_t ST_MONTH  = 4'd11;
  localparam pc_t ST_EMIT   = 4'd12;

  localparam logic [ShiftW-1:0] KDay  = 5'd16;
  localparam logic [ShiftW-1:0] KHour = 5'd4;
  localparam logic [ShiftW-1:0] KMin  = 5'd5;
  localparam logic [ShiftW-1:0] KWeek = 5'd12;
  localparam logic [ShiftW-1:0] KNone = 5'd0;

  // Microprogram: a jump goes to tgt when the step's condition holds
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_MOVQ, dsel: DV_DAY, dst: DST_NONE, k: KNone, tgt: ST_WAIT};
    case (pc)
      ST_WAIT:  w = '{op: OP_WAIT,  dsel: DV_DAY,  dst: DST_NONE, k: KDay,  tgt: ST_WAIT};
      ST_DDAY:  w = '{op: OP_DIV,   dsel: DV_DAY,  dst: DST_NONE, k: KNone, tgt: ST_DDAY};
      ST_MDAY:  w = '{op: OP_MOVQ,  dsel: DV_DAY,  dst: DST_DAYS, k: KHour, tgt: ST_WAIT};
      ST_DHOUR: w = '{op: OP_DIV,   dsel: DV_HOUR, dst: DST_NONE, k: KNone, tgt: ST_DHOUR};
      ST_MHOUR: w = '{op: OP_MOVQ,  dsel: DV_DAY,  dst: DST_HOUR, k: KMin,  tgt: ST_WAIT};
      ST_DMIN:  w = '{op: OP_DIV,   dsel: DV_MIN,  dst: DST_NONE, k: KNone, tgt: ST_DMIN};
      ST_MMIN:  w = '{op: OP_MOVQ,  dsel: DV_DAY,  dst: DST_MIN,  k: KNone, tgt: ST_WAIT};
      ST_SSEC:  w = '{op: OP_SWAP,  dsel: DV_DAY,  dst: DST_SEC,  k: KWeek, tgt: ST_WAIT};
      ST_DWEEK: w = '{op: OP_DIV,   dsel: DV_WEEK, dst: DST_NONE, k: KNone, tgt: ST_DWEEK};
      ST_SWDAY: w = '{op: OP_SWAP,  dsel: DV_DAY,  dst: DST_WDAY, k: KNone, tgt: ST_WAIT};
      ST_YEAR:  w = '{op: OP_YEAR,  dsel: DV_DAY,  dst: DST_NONE, k: KNone, tgt: ST_YEAR};
      ST_MONTH: w = '{op: OP_MONTH, dsel: DV_DAY,  dst: DST_NONE, k: KNone, tgt: ST_MONTH};
      ST_EMIT:  w = '{op: OP_EMIT,  dsel: DV_DAY,  dst: DST_NONE, k: KNone, tgt: ST_WAIT};
      default:  w = '{op: OP_MOVQ,  dsel: DV_DAY,  dst: DST_NONE, k: KNone, tgt: ST_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [DivW-1:0] div_const(input dsel_e sel);
    logic [DivW-1:0] v;
    case (sel)
      DV_DAY:  v = SecsPerDay;
      DV_HOUR: v = SecsPerHour;
      DV_MIN:  v = SecsPerMin;
      DV_WEEK: v = DaysPerWeek;
      default: v = SecsPerDay;
    endcase
    return v;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] v;
    case (m)
      4'd2:    v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/s2cd_in_if.sv */
`default_nettype none
interface s2cd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_count;

  modport source (output valid, output seconds_count, input ready);
  modport sink   (input valid, input seconds_count, output ready);
endinterface
`default_nettype wire

/* rtl/s2cd_out_if.sv */
`default_nettype none
interface s2cd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] calendar_year;
  logic [3:0]  calendar_month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [2:0]  weekday;

  modport source (output valid, output calendar_year, output calendar_month,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output weekday, input ready);
  modport sink   (input valid, input calendar_year, input calendar_month,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, input weekday, output ready);
endinterface
`default_nettype wire

/* rtl/s2cd_sequencer.sv */
`default_nettype none
module s2cd_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire s2cd_pkg::stat_t stat_i,
  output s2cd_pkg::ctrl_t    ctrl_o
);
  import s2cd_pkg::*;

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  logic  hold, jump;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    hold = 1'b0;
    jump = 1'b0;
    case (ctrl.op)
      OP_WAIT:  hold = !stat_i.fire;
      OP_DIV:   jump = stat_i.k_nz;
      OP_YEAR:  jump = stat_i.ge;
      OP_MONTH: jump = stat_i.ge;
      OP_EMIT: begin
        hold = !stat_i.out_free;
        jump = stat_i.out_free;
      end
      default: begin
        hold = 1'b0;
        jump = 1'b0;
      end
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ctrl.tgt;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/s2cd_datapath.sv */
`default_nettype none
module s2cd_datapath (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  s2cd_in_if.sink         in_i,
  s2cd_out_if.source      out_o,
  input  wire s2cd_pkg::ctrl_t ctrl_i,
  output s2cd_pkg::stat_t stat_o
);
  import s2cd_pkg::*;

  // working registers
  logic [SecsW-1:0]  a_q, a_d;
  logic [QuotW-1:0]  q_q, q_d;
  logic [ShiftW-1:0] k_q, k_d;
  logic [DaysW-1:0]  days_q, days_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [WdayW-1:0]  wday_q, wday_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [YearW-1:0]  o_year_q;
  logic [MonthW-1:0] o_month_q;
  logic [DayW-1:0]   o_day_q;
  logic [HourW-1:0]  o_hour_q;
  logic [MinW-1:0]   o_min_q;
  logic [SecW-1:0]   o_sec_q;
  logic [WdayW-1:0]  o_wday_q;

  logic              fire, out_free, emit, leap, ge;
  logic [YlenW-1:0]  ylen;
  logic [DayW-1:0]   mlen;
  logic [SubW-1:0]   sub_a, sub_b, diff;

  assign in_i.ready = (ctrl_i.op == OP_WAIT);
  assign fire       = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = (ctrl_i.op == OP_EMIT) && out_free;

  // Valid for 2017..2153: 2100 is the only century year in reach
  assign leap = (year_q[1:0] == 2'b00) && (year_q != CenturyNoLeap);
  assign ylen = leap ? DaysLeapYear : DaysCommonYear;
  assign mlen = month_len(month_q, leap);

  // Shared compare-subtract unit
  always_comb begin
    case (ctrl_i.op)
      OP_DIV:   sub_b = SubW'(div_const(ctrl_i.dsel)) << k_q;
      OP_YEAR:  sub_b = SubW'(ylen);
      OP_MONTH: sub_b = SubW'(mlen);
      default:  sub_b = '0;
    endcase
  end
  assign sub_a = {1'b0, a_q};
  assign ge    = (sub_a >= sub_b);
  assign diff  = sub_a - sub_b;

  assign stat_o = '{fire: fire, k_nz: (k_q != '0), ge: ge, out_free: out_free};

  always_comb begin
    a_d     = a_q;
    q_d     = q_q;
    k_d     = k_q;
    days_d  = days_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    wday_d  = wday_q;
    year_d  = year_q;
    month_d = month_q;
    case (ctrl_i.op)
      OP_WAIT: begin
        q_d = '0;
        k_d = ctrl_i.k;
        if (fire) begin
          a_d = in_i.seconds_count;
        end
      end
      OP_DIV: begin
        // restoring long division, one quotient bit per step
        if (ge) begin
          a_d      = diff[SecsW-1:0];
          q_d[k_q] = 1'b1;
        end
        if (k_q != '0) begin
          k_d = k_q - ShiftW'(1);
        end
      end
      OP_MOVQ: begin
        case (ctrl_i.dst)
          DST_DAYS: days_d = q_q[DaysW-1:0];
          DST_HOUR: hour_d = q_q[HourW-1:0];
          DST_MIN:  min_d  = q_q[MinW-1:0];
          default:  days_d = days_q;
        endcase
        q_d = '0;
        k_d = ctrl_i.k;
      end
      OP_SWAP: begin
        // save the remainder, reload the day count
        case (ctrl_i.dst)
          DST_SEC:  sec_d  = a_q[SecW-1:0];
          DST_WDAY: wday_d = a_q[WdayW-1:0];
          default:  sec_d  = sec_q;
        endcase
        a_d     = SecsW'(days_q);
        q_d     = '0;
        k_d     = ctrl_i.k;
        year_d  = EpochYear;
        month_d = FirstMonth;
      end
      OP_YEAR: begin
        if (ge) begin
          a_d    = diff[SecsW-1:0];
          year_d = year_q + YearW'(1);
        end
      end
      OP_MONTH: begin
        if (ge) begin
          a_d     = diff[SecsW-1:0];
          month_d = month_q + MonthW'(1);
        end
      end
      default: begin
        a_d = a_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    q_q     <= q_d;
    k_q     <= k_d;
    days_q  <= days_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    wday_q  <= wday_d;
    year_q  <= year_d;
    month_q <= month_d;
    if (emit) begin
      o_year_q  <= year_q;
      o_month_q <= month_q;
      o_day_q   <= a_q[DayW-1:0] + DayW'(1);
      o_hour_q  <= hour_q;
      o_min_q   <= min_q;
      o_sec_q   <= sec_q;
      o_wday_q  <= wday_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.calendar_year    = o_year_q;
  assign out_o.calendar_month   = o_month_q;
  assign out_o.day_of_month     = o_day_q;
  assign out_o.hour_of_day      = o_hour_q;
  assign out_o.minute_of_hour   = o_min_q;
  assign out_o.second_of_minute = o_sec_q;
  assign out_o.weekday          = o_wday_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !in_i.ready)
    else $error("input accepted while a conversion is in flight");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_month_q >= 4'd1) && (o_month_q <= 4'd12))
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_hour_q < 5'd24) && (o_min_q < 6'd60) && (o_sec_q < 6'd60))
    else $error("time of day out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_day_q != 5'd0) && (o_wday_q < 3'd7))
    else $error("day or weekday out of range");

endmodule
`default_nettype wire

/* rtl/seconds_to_calendar_date_core.sv */
// Converts a 32-bit count of seconds since 2017-01-01 00:00:00 into the
// Gregorian year, month, day, hour, minute, second and weekday (0 is Sunday).
// One transaction is converted at a time: a short microprogram steers a
// single 33-bit compare-subtract unit through long division by 86400, 3600,
// 60 and 7, then walks whole years and months by subtraction. The block
// is ready for the next transaction in the same cycle that the result
// appears at the output, while that result may still wait there.
`default_nettype none
module seconds_to_calendar_date_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  s2cd_in_if.sink    in_i,
  s2cd_out_if.source out_o
);
  import s2cd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  s2cd_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  s2cd_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule
`default_nettype wire

/* bench/tb_seconds_to_calendar_date_core.sv */
`timescale 1ns / 100ps
module tb_seconds_to_calendar_date_core;
  import s2cd_pkg::*;

  localparam int unsigned NumRandom   = 900;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned HoldOffAt   = 300;
  localparam int unsigned HoldOffLen  = 3000;

  typedef struct packed {
    logic [YearW-1:0]  calendar_year;
    logic [MonthW-1:0] calendar_month;
    logic [DayW-1:0]   day_of_month;
    logic [HourW-1:0]  hour_of_day;
    logic [MinW-1:0]   minute_of_hour;
    logic [SecW-1:0]   second_of_minute;
    logic [WdayW-1:0]  weekday;
  } cal_date_t;

  logic clk_i;
  logic rst_ni;

  s2cd_in_if  in_if ();
  s2cd_out_if out_if ();

  seconds_to_calendar_date_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  function automatic bit leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned yr, int unsigned mo);
    case (mo)
      2:            return leap_year(yr) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Seconds since the epoch for a given date and time of day
  function automatic longint date_to_seconds(int unsigned yr, int unsigned mo,
                                             int unsigned md, int unsigned hh,
                                             int unsigned mm, int unsigned ss);
    longint days;
    days = md - 1;
    for (int unsigned y = 2017; y < yr; y++) days += leap_year(y) ? 366 : 365;
    for (int unsigned m = 1; m < mo; m++) days += days_in_month(yr, m);
    return days * 86400 + hh * 3600 + mm * 60 + ss;
  endfunction

  class date_scoreboard;
    cal_date_t   expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function cal_date_t convert(bit [31:0] secs);
      cal_date_t   d;
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mo;
      days = secs / 86400;
      tod  = secs % 86400;
      d.weekday = WdayW'(days % 7);
      yr = 2017;
      while (days >= (leap_year(yr) ? 366 : 365)) begin
        days -= leap_year(yr) ? 366 : 365;
        yr++;
      end
      mo = 1;
      while (mo < 12 && days >= days_in_month(yr, mo)) begin
        days -= days_in_month(yr, mo);
        mo++;
      end
      d.calendar_year    = YearW'(yr);
      d.calendar_month   = MonthW'(mo);
      d.day_of_month     = DayW'(days + 1);
      d.hour_of_day      = HourW'(tod / 3600);
      d.minute_of_hour   = MinW'((tod % 3600) / 60);
      d.second_of_minute = SecW'(tod % 60);
      return d;
    endfunction

    function void note_seconds(bit [31:0] secs);
      expected_q.push_back(convert(secs));
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_date(cal_date_t got);
      cal_date_t want;
      if (expected_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.calendar_year != want.calendar_year)
        flag("calendar_year", want.calendar_year, got.calendar_year);
      if (got.calendar_month != want.calendar_month)
        flag("calendar_month", want.calendar_month, got.calendar_month);
      if (got.day_of_month != want.day_of_month)
        flag("day_of_month", want.day_of_month, got.day_of_month);
      if (got.hour_of_day != want.hour_of_day)
        flag("hour_of_day", want.hour_of_day, got.hour_of_day);
      if (got.minute_of_hour != want.minute_of_hour)
        flag("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
      if (got.second_of_minute != want.second_of_minute)
        flag("second_of_minute", want.second_of_minute, got.second_of_minute);
      if (got.weekday != want.weekday)
        flag("weekday", want.weekday, got.weekday);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  date_scoreboard date_sb = new();
  int unsigned    burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one transaction and hold it until the block takes it; then maybe idle
  task automatic send_seconds(bit [31:0] secs);
    int unsigned gap;
    in_if.valid         <= 1'b1;
    in_if.seconds_count <= secs;
    do @(posedge clk_i); while (!in_if.ready);
    date_sb.note_seconds(secs);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Pick a count near a day, month or year boundary
  function automatic bit [31:0] boundary_seconds();
    int unsigned yr;
    int unsigned mo;
    int unsigned md;
    longint      s;
    yr = $urandom_range(2017, 2152);
    if ($urandom_range(0, 3) == 0) yr = 2100 + 4 * $urandom_range(0, 2) - 4;
    mo = $urandom_range(1, 12);
    md = $urandom_range(0, 1) ? days_in_month(yr, mo) : 1;
    s = date_to_seconds(yr, mo, md, $urandom_range(0, 1) ? 23 : 0,
                        $urandom_range(0, 1) ? 59 : 0, $urandom_range(0, 1) ? 59 : 0);
    s += longint'($urandom_range(0, 2)) - 1;
    if (s < 0) s = 0;
    return 32'(s);
  endfunction

  initial begin
    bit [31:0] directed_q[$];
    in_if.valid         <= 1'b0;
    in_if.seconds_count <= '0;
    rst_ni              <= 1'b0;
    burst_left          = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_q = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'(date_to_seconds(2018, 1, 1, 0, 0, 0) - 1),
                   32'(date_to_seconds(2018, 1, 1, 0, 0, 0)),
                   32'(date_to_seconds(2020, 2, 28, 23, 59, 59)),
                   32'(date_to_seconds(2020, 2, 29, 12, 30, 30)),
                   32'(date_to_seconds(2020, 3, 1, 0, 0, 0)),
                   32'(date_to_seconds(2020, 12, 31, 23, 59, 59)),
                   32'(date_to_seconds(2100, 2, 28, 23, 59, 59)),
                   32'(date_to_seconds(2100, 3, 1, 0, 0, 0)),
                   32'(date_to_seconds(2104, 2, 29, 6, 0, 0)),
                   32'(date_to_seconds(2152, 12, 31, 23, 59, 59)),
                   32'(date_to_seconds(2153, 1, 1, 0, 0, 0))};
    foreach (directed_q[i]) send_seconds(directed_q[i]);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_seconds($urandom);
        5:             send_seconds($urandom_range(0, 200_000));
        default:       send_seconds(boundary_seconds());
      endcase
    end
    in_if.valid <= 1'b0;

    while (date_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (date_sb.errors == 0 && date_sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: check each transaction, stall on a pattern that changes mode
  initial begin
    cal_date_t   got;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned results_seen;
    out_if.ready <= 1'b0;
    mode         = 0;
    mode_left    = 0;
    hold_left    = 0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.calendar_year    = out_if.calendar_year;
        got.calendar_month   = out_if.calendar_month;
        got.day_of_month     = out_if.day_of_month;
        got.hour_of_day      = out_if.hour_of_day;
        got.minute_of_hour   = out_if.minute_of_hour;
        got.second_of_minute = out_if.second_of_minute;
        got.weekday          = out_if.weekday;
        date_sb.check_date(got);
        results_seen++;
        // Hold off once for a long stretch so the input side backs up
        if (results_seen == HoldOffAt) hold_left = HoldOffLen;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 2000);
      end
      mode_left--;
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= $urandom_range(0, 1);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

endmodule
